### hw/rtl/pcpf_pkg.sv
// Package for the path cost and peak field core.
// Holds sizing constants, register codes, controller states and the command/status types.
// No dependencies.
`default_nettype none

package pcpf_pkg;

   localparam int GRID_COLS_MAX = 64;
   localparam int GRID_ROWS_MAX = 64;
   localparam int SAMPLES_PER_SEGMENT = 16;

   localparam int STORE_DEPTH = GRID_COLS_MAX * GRID_ROWS_MAX;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int COL_W = $clog2(GRID_COLS_MAX);
   localparam int ROW_W = $clog2(GRID_ROWS_MAX);
   localparam int DIM_W = 7;
   localparam int CMP_W = 10;
   localparam int FIELD_W = 16;

   localparam int LOG2N = $clog2(SAMPLES_PER_SEGMENT);
   localparam int LOG2_2N = LOG2N + 1;
   localparam int TWO_N = 2 * SAMPLES_PER_SEGMENT;
   localparam int K_W = $clog2(TWO_N + 1);
   localparam int POS_W = 18 + LOG2N + 1;
   localparam int NUM_W = POS_W + 17;
   localparam int S_W = 16 + LOG2N;
   localparam int GX_W = 16 + COL_W;
   localparam int GY_W = 16 + ROW_W;

   localparam int SQRT_STEPS = 25;
   localparam int SQ_CNT_W = 5;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH,
      REG_GRID_HEIGHT,
      REG_CELL_INVERSE,
      REG_SMOOTH_WEIGHT
   } csr_reg_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_POINT = 1'b1
   } op_kind_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_LOAD, DP_LATCH, DP_PREP, DP_SQINIT, DP_SQSTEP,
      DP_COORD, DP_ADDR, DP_RD0, DP_RD1, DP_RD2, DP_RD3, DP_INT0, DP_INT1,
      DP_COST0, DP_COST1, DP_ACC, DP_HIST, DP_TOT0, DP_TOT1, DP_EMIT
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP, ST_SQINIT, ST_SQRT, ST_COORD, ST_ADDR,
      ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_INT0, ST_INT1,
      ST_COST0, ST_COST1, ST_ACC, ST_HIST, ST_TOT0, ST_TOT1, ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic has_prev;
      logic is_last;
      logic sqrt_last;
      logic samples_last;
      logic slot_free;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/pcpf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### hw/rtl/pcpf_ctrl.sv
// Controller state machine of the path cost and peak field core.
// Depends on pcpf_pkg; drives the datapath through one command per cycle.
`default_nettype none

module pcpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   output logic                   req_tready,
   input  pcpf_pkg::status_type   status,
   output pcpf_pkg::dp_op_type    cmd
);
   import pcpf_pkg::*;

   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tuser == OP_POINT) begin
               state_in = status.has_prev ? ST_PREP : ST_ACC;
            end
         end
         ST_PREP:   state_in = ST_SQINIT;
         ST_SQINIT: state_in = ST_SQRT;
         ST_SQRT: begin
            if (status.sqrt_last) begin
               state_in = ST_COORD;
            end
         end
         ST_COORD:  state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_RD0;
         ST_RD0:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_RD2;
         ST_RD2:    state_in = ST_RD3;
         ST_RD3:    state_in = ST_INT0;
         ST_INT0:   state_in = ST_INT1;
         ST_INT1:   state_in = status.samples_last ? ST_COST0 : ST_COORD;
         ST_COST0:  state_in = ST_COST1;
         ST_COST1:  state_in = ST_ACC;
         ST_ACC:    state_in = ST_HIST;
         ST_HIST:   state_in = status.is_last ? ST_TOT0 : ST_IDLE;
         ST_TOT0:   state_in = ST_TOT1;
         ST_TOT1:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd = DP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd = (req_tuser == OP_POINT) ? DP_LATCH : DP_LOAD;
            end
         end
         ST_PREP:   cmd = DP_PREP;
         ST_SQINIT: cmd = DP_SQINIT;
         ST_SQRT:   cmd = DP_SQSTEP;
         ST_COORD:  cmd = DP_COORD;
         ST_ADDR:   cmd = DP_ADDR;
         ST_RD0:    cmd = DP_RD0;
         ST_RD1:    cmd = DP_RD1;
         ST_RD2:    cmd = DP_RD2;
         ST_RD3:    cmd = DP_RD3;
         ST_INT0:   cmd = DP_INT0;
         ST_INT1:   cmd = DP_INT1;
         ST_COST0:  cmd = DP_COST0;
         ST_COST1:  cmd = DP_COST1;
         ST_ACC:    cmd = DP_ACC;
         ST_HIST:   cmd = DP_HIST;
         ST_TOT0:   cmd = DP_TOT0;
         ST_TOT1:   cmd = DP_TOT1;
         ST_EMIT:   cmd = status.slot_free ? DP_EMIT : DP_NONE;
         default:   cmd = DP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_sqrt_runs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT && !status.sqrt_last |=> state_ff == ST_SQRT)
      else $error("square root left before its last step");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd == DP_EMIT |-> status.slot_free)
      else $error("result issued into an occupied output register");
`endif

endmodule

`default_nettype wire

### hw/rtl/pcpf_dp.sv
// Datapath of the path cost and peak field core: registers, grid RAM, square root,
// bilinear sampler, accumulators and output register. Depends on pcpf_pkg and pcpf_ram.
`default_nettype none

module pcpf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pcpf_pkg::dp_op_type                 cmd,
   output pcpf_pkg::status_type                status,
   input  logic [pcpf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcpf_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pcpf_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import pcpf_pkg::*;

   function automatic logic [47:0] sat48(input logic [47:0] a, input logic [55:0] b);
      logic [56:0] s;
      s = {9'b0, a} + {1'b0, b};
      return (s[56:48] != 9'b0) ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

   logic [DIM_W-1:0] gw_ff, gw_in, gh_ff, gh_in;
   logic [15:0] cinv_ff, cinv_in, sw_ff, sw_in;
   logic [15:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic last_ff, last_in;
   logic [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [15:0] older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic [1:0] pts_ff, pts_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [49:0] rad_ff, rad_in;
   logic [26:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [SQ_CNT_W-1:0] sq_cnt_ff, sq_cnt_in;
   logic [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [K_W-1:0] k_ff, k_in;
   logic [GX_W-1:0] gx_ff, gx_in;
   logic [GY_W-1:0] gy_ff, gy_in;
   logic [COL_W-1:0] ix_ff, ix_in, ix1_ff, ix1_in;
   logic [ADDR_W-1:0] row0_ff, row0_in, row1_ff, row1_in;
   logic [15:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [15:0] c00_ff, c00_in, c10_ff, c10_in, c01_ff, c01_in;
   logic signed [33:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [S_W-1:0] ssum_ff, ssum_in;
   logic [15:0] peak_ff, peak_in;
   logic [S_W+12:0] plo_ff, plo_in;
   logic [47:0] obst_ff, obst_in, smooth_ff, smooth_in;
   logic [37:0] sq_ff, sq_in;
   logic [39:0] tlo_ff, tlo_in;
   logic [47:0] total_ff, total_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0] eff_w, eff_h;
   logic [15:0] rdata;
   logic [ADDR_W-1:0] rd_addr;
   logic ram_we;
   logic [11:0] req_index;

   logic signed [33:0] dx_sq, dy_sq;
   logic [33:0] ss;
   logic [27:0] rem_next, sq_trial;
   logic sq_ge;
   logic signed [NUM_W-1:0] num_x, num_y, sh_x, sh_y, gmax_x, gmax_y;
   logic [ROW_W-1:0] iy, iy1;
   logic [COL_W-1:0] ix;
   logic signed [16:0] d10, d11;
   logic signed [33:0] p0, p1;
   logic signed [33:0] dr;
   logic signed [51:0] pv, v;
   logic [51:0] fr;
   logic [15:0] fval;
   logic [S_W+11:0] phi;
   logic [S_W+24:0] pfull;
   logic [18:0] acc_x, acc_y;
   logic signed [37:0] acc_x_sq, acc_y_sq;
   logic [39:0] thi;
   logic [63:0] tfull;

   assign req_index = req_tdata[11:0];
   assign csr_ready = 1'b1;

   always_comb begin
      eff_w = gw_ff;
      if (gw_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (gw_ff > GRID_COLS_MAX) begin
         eff_w = DIM_W'(GRID_COLS_MAX);
      end
      eff_h = gh_ff;
      if (gh_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (gh_ff > GRID_ROWS_MAX) begin
         eff_h = DIM_W'(GRID_ROWS_MAX);
      end
   end

   assign ram_we = (cmd == DP_LOAD) && (req_index < STORE_DEPTH);

   always_comb begin
      unique case (cmd)
         DP_RD1:  rd_addr = row0_ff + ADDR_W'(ix1_ff);
         DP_RD2:  rd_addr = row1_ff + ADDR_W'(ix_ff);
         DP_RD3:  rd_addr = row1_ff + ADDR_W'(ix1_ff);
         default: rd_addr = row0_ff + ADDR_W'(ix_ff);
      endcase
   end

   pcpf_ram #(.WIDTH(FIELD_W), .DEPTH(STORE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(req_index)),
      .wdata (req_tdata[27:12]),
      .raddr (rd_addr),
      .rdata (rdata)
   );

   always_comb begin
      dx_sq = dx_ff * dx_ff;
      dy_sq = dy_ff * dy_ff;
      ss = {1'b0, dx_sq[32:0]} + {1'b0, dy_sq[32:0]};

      rem_next = {rem_ff[25:0], rad_ff[49:48]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge = rem_next >= sq_trial;

      num_x = $signed(pos_x_ff) * $signed({1'b0, cinv_ff});
      num_y = $signed(pos_y_ff) * $signed({1'b0, cinv_ff});
      sh_x = num_x >>> LOG2_2N;
      sh_y = num_y >>> LOG2_2N;
      gmax_x = NUM_W'({eff_w - DIM_W'(1), 16'b0});
      gmax_y = NUM_W'({eff_h - DIM_W'(1), 16'b0});

      ix = gx_ff[GX_W-1:16];
      iy = gy_ff[GY_W-1:16];
      iy1 = (CMP_W'(iy) + CMP_W'(1) < CMP_W'(eff_h)) ? iy + ROW_W'(1) : iy;

      d10 = $signed({1'b0, c10_ff}) - $signed({1'b0, c00_ff});
      d11 = $signed({1'b0, rdata}) - $signed({1'b0, c01_ff});
      p0 = $signed({1'b0, fx_ff}) * d10;
      p1 = $signed({1'b0, fx_ff}) * d11;

      dr = r1_ff - r0_ff;
      pv = $signed({1'b0, fy_ff}) * dr;
      v = $signed({{2{r0_ff[33]}}, r0_ff, 16'b0}) + pv;
      fr = (v[51] ? 52'd0 : 52'(v)) + 52'h0_0000_8000_0000;
      fval = fr[47:32];

      phi = ssum_ff * root_ff[24:13];
      pfull = (S_W+25)'(plo_ff) + ((S_W+25)'(phi) << 13);

      acc_x = {{3{older_x_ff[15]}}, older_x_ff} - {{2{prev_x_ff[15]}}, prev_x_ff, 1'b0}
            + {{3{cur_x_ff[15]}}, cur_x_ff};
      acc_y = {{3{older_y_ff[15]}}, older_y_ff} - {{2{prev_y_ff[15]}}, prev_y_ff, 1'b0}
            + {{3{cur_y_ff[15]}}, cur_y_ff};
      acc_x_sq = $signed(acc_x) * $signed(acc_x);
      acc_y_sq = $signed(acc_y) * $signed(acc_y);

      thi = smooth_ff[47:24] * sw_ff;
      tfull = 64'(tlo_ff) + (64'(thi) << 24);
   end

   always_comb begin
      gw_in = gw_ff;
      gh_in = gh_ff;
      cinv_in = cinv_ff;
      sw_in = sw_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_GRID_WIDTH:    gw_in = csr_data[DIM_W-1:0];
            REG_GRID_HEIGHT:   gh_in = csr_data[DIM_W-1:0];
            REG_CELL_INVERSE:  cinv_in = csr_data;
            REG_SMOOTH_WEIGHT: sw_in = csr_data;
            default:           gw_in = gw_ff;
         endcase
      end
   end

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      last_in = last_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      older_x_in = older_x_ff;
      older_y_in = older_y_ff;
      pts_in = pts_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      sq_cnt_in = sq_cnt_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      k_in = k_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      ix_in = ix_ff;
      ix1_in = ix1_ff;
      row0_in = row0_ff;
      row1_in = row1_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      c00_in = c00_ff;
      c10_in = c10_ff;
      c01_in = c01_ff;
      r0_in = r0_ff;
      r1_in = r1_ff;
      ssum_in = ssum_ff;
      peak_in = peak_ff;
      plo_in = plo_ff;
      obst_in = obst_ff;
      smooth_in = smooth_ff;
      sq_in = sq_ff;
      tlo_in = tlo_ff;
      total_in = total_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      unique case (cmd)
         DP_LATCH: begin
            cur_x_in = req_tdata[43:28];
            cur_y_in = req_tdata[59:44];
            last_in = req_tlast;
         end
         DP_PREP: begin
            dx_in = $signed({cur_x_ff[15], cur_x_ff}) - $signed({prev_x_ff[15], prev_x_ff});
            dy_in = $signed({cur_y_ff[15], cur_y_ff}) - $signed({prev_y_ff[15], prev_y_ff});
            pos_x_in = {{(POS_W-16-LOG2_2N){prev_x_ff[15]}}, prev_x_ff, {LOG2_2N{1'b0}}};
            pos_y_in = {{(POS_W-16-LOG2_2N){prev_y_ff[15]}}, prev_y_ff, {LOG2_2N{1'b0}}};
            k_in = '0;
            ssum_in = '0;
         end
         DP_SQINIT: begin
            rad_in = {ss, 16'b0};
            rem_in = '0;
            root_in = '0;
            sq_cnt_in = '0;
         end
         DP_SQSTEP: begin
            rem_in = sq_ge ? 27'(rem_next - sq_trial) : 27'(rem_next);
            root_in = {root_ff[23:0], sq_ge};
            rad_in = {rad_ff[47:0], 2'b00};
            sq_cnt_in = sq_cnt_ff + SQ_CNT_W'(1);
         end
         DP_COORD: begin
            gx_in = num_x[NUM_W-1] ? '0 : ((sh_x > gmax_x) ? GX_W'(gmax_x) : GX_W'(sh_x));
            gy_in = num_y[NUM_W-1] ? '0 : ((sh_y > gmax_y) ? GY_W'(gmax_y) : GY_W'(sh_y));
         end
         DP_ADDR: begin
            ix_in = ix;
            ix1_in = (CMP_W'(ix) + CMP_W'(1) < CMP_W'(eff_w)) ? ix + COL_W'(1) : ix;
            fx_in = gx_ff[15:0];
            fy_in = gy_ff[15:0];
            row0_in = ADDR_W'(ADDR_W'(iy) * ADDR_W'(eff_w));
            row1_in = ADDR_W'(ADDR_W'(iy1) * ADDR_W'(eff_w));
         end
         DP_RD1: c00_in = rdata;
         DP_RD2: c10_in = rdata;
         DP_RD3: c01_in = rdata;
         DP_INT0: begin
            r0_in = $signed({2'b00, c00_ff, 16'b0}) + p0;
            r1_in = $signed({2'b00, c01_ff, 16'b0}) + p1;
         end
         DP_INT1: begin
            if (k_ff[0]) begin
               ssum_in = ssum_ff + S_W'(fval);
            end else if (fval > peak_ff) begin
               peak_in = fval;
            end
            k_in = k_ff + K_W'(1);
            pos_x_in = pos_x_ff + {{(POS_W-17){dx_ff[16]}}, dx_ff};
            pos_y_in = pos_y_ff + {{(POS_W-17){dy_ff[16]}}, dy_ff};
         end
         DP_COST0: plo_in = ssum_ff * root_ff[12:0];
         DP_COST1: obst_in = sat48(obst_ff, 56'(pfull[S_W+24:LOG2N+8]));
         DP_ACC: sq_in = {1'b0, acc_x_sq[36:0]} + {1'b0, acc_y_sq[36:0]};
         DP_HIST: begin
            if (pts_ff == 2'd2) begin
               smooth_in = sat48(smooth_ff, 56'(sq_ff));
            end
            older_x_in = prev_x_ff;
            older_y_in = prev_y_ff;
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            if (pts_ff != 2'd2) begin
               pts_in = pts_ff + 2'd1;
            end
         end
         DP_TOT0: tlo_in = smooth_ff[23:0] * sw_ff;
         DP_TOT1: total_in = sat48(obst_ff, tfull[63:8]);
         DP_EMIT: begin
            rsp_data_in = {peak_ff, total_ff};
            rsp_valid_in = 1'b1;
            prev_x_in = '0;
            prev_y_in = '0;
            older_x_in = '0;
            older_y_in = '0;
            pts_in = '0;
            obst_in = '0;
            smooth_in = '0;
            peak_in = '0;
         end
         default: pts_in = pts_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= DIM_W'(64);
         gh_ff <= DIM_W'(64);
         cinv_ff <= 16'd256;
         sw_ff <= 16'd256;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         older_x_ff <= '0;
         older_y_ff <= '0;
         pts_ff <= '0;
         obst_ff <= '0;
         smooth_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gw_ff <= gw_in;
         gh_ff <= gh_in;
         cinv_ff <= cinv_in;
         sw_ff <= sw_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         older_x_ff <= older_x_in;
         older_y_ff <= older_y_in;
         pts_ff <= pts_in;
         obst_ff <= obst_in;
         smooth_ff <= smooth_in;
         peak_ff <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      last_ff <= last_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      sq_cnt_ff <= sq_cnt_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      k_ff <= k_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      ix_ff <= ix_in;
      ix1_ff <= ix1_in;
      row0_ff <= row0_in;
      row1_ff <= row1_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      c00_ff <= c00_in;
      c10_ff <= c10_in;
      c01_ff <= c01_in;
      r0_ff <= r0_in;
      r1_ff <= r1_in;
      ssum_ff <= ssum_in;
      plo_ff <= plo_in;
      sq_ff <= sq_in;
      tlo_ff <= tlo_in;
      total_ff <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.has_prev = pts_ff != 2'd0;
   assign status.is_last = last_ff;
   assign status.sqrt_last = sq_cnt_ff == SQ_CNT_W'(SQRT_STEPS - 1);
   assign status.samples_last = k_ff == K_W'(TWO_N);
   assign status.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_pts_range: assert property (@(posedge clock) disable iff (reset)
      pts_ff != 2'd3)
      else $error("point counter out of range");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd == DP_EMIT |=> rsp_valid_ff && obst_ff == '0 && smooth_ff == '0 && peak_ff == '0)
      else $error("path state not cleared after a result");
`endif

endmodule

`default_nettype wire

### hw/rtl/path_cost_and_peak_field_core.sv
// Top level of the path cost and peak field core.
// Depends on pcpf_pkg, pcpf_ctrl and pcpf_dp.
//
// Usage: write the four registers over the csr channel while the core is idle, load the
// cost grid with words whose tuser is 0 (one cell each, taken in one cycle), then send
// path points with tuser 1 and tlast on the final point of a path. The last point
// produces one result word: total cost in the low 48 bits and peak field above it.
// A point with no predecessor keeps the core busy in the ACC and HIST states after it is
// taken. A point that closes a segment runs PREP, SQINIT, the 25 steps of the bit-serial
// square root, and for each sample four reads from the single-port grid RAM plus
// coordinate, address and interpolation states, then COST0, COST1, ACC and HIST. A last
// point adds TOT0, TOT1 and EMIT for the weighted total. Reset returns registers to their
// defaults and clears the path; the grid contents are undefined until loaded. The result
// sits in an output register, so the core takes new words while it waits; if a second
// result is ready while the first still waits, the core holds until the receiver takes it.
`default_nettype none

module path_cost_and_peak_field_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cell_index[11:0], cell_value[27:12], point_x[43:28], point_y[59:44], zero fill
   input  logic [pcpf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // operation[0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // total_cost[47:0], peak_value[63:48]
   output logic [pcpf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcpf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pcpf_pkg::*;

   dp_op_type cmd;
   status_type status;

   pcpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcpf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### verif/path_cost_and_peak_field_core_tb.sv
// Self-checking testbench for path_cost_and_peak_field_core: cost grid loads, path points,
// register phases and stalls on both stream sides, checked by a behavioral cost predictor.
// Depends on pcpf_pkg and the core RTL.
`default_nettype none

module path_cost_and_peak_field_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;
   localparam int PRESSURE_CYCLES = 3000;
   localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      bit [47:0] cost;
      bit [15:0] peak;
   } path_result_type;

   typedef struct {
      op_kind_type op;
      int          idx;
      int          val;
      int          px;
      int          py;
      bit          last;
      bit          known;
      bit [47:0]   cost;
      bit [15:0]   peak;
   } stim_row_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   path_cost_and_peak_field_core dut (.*);

   // Predictor state.
   bit [6:0]    width_reg, height_reg;
   bit [15:0]   inverse_reg, weight_reg;
   bit [15:0]   grid_cells[STORE_DEPTH];
   bit          cell_loaded[STORE_DEPTH];
   longint      prev_px, prev_py, older_px, older_py;
   int          points_held;
   bit [63:0]   obstacle_acc, smooth_acc;
   bit [15:0]   peak_acc;

   path_result_type expected_q[$];
   int          err_count = 0;
   int          rsp_count = 0;
   bit          req_gaps_on = 1, rsp_gaps_on = 1;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_dim(bit [6:0] r, int mx);
      longint d = r;
      if (d < 1) d = 1;
      if (d > mx) d = mx;
      return d;
   endfunction

   function automatic longint grid_pos(longint a, longint d, longint k, longint dim);
      longint twon = 2 * SAMPLES_PER_SEGMENT;
      longint num = (a * twon + k * d) * longint'(inverse_reg);
      longint g = (num < 0) ? 0 : num / twon;
      longint gmax = (dim - 1) * 65536;
      return (g > gmax) ? gmax : g;
   endfunction

   function automatic longint field_sample(longint ax, longint ay, longint dx, longint dy,
                                           longint k);
      longint gw, gh, gx, gy, ix, iy, fx, fy, ix1, iy1, c00, c10, c01, c11, r0, r1, v;
      gw = clamp_dim(width_reg, GRID_COLS_MAX);
      gh = clamp_dim(height_reg, GRID_ROWS_MAX);
      gx = grid_pos(ax, dx, k, gw);
      gy = grid_pos(ay, dy, k, gh);
      ix = gx / 65536;
      iy = gy / 65536;
      fx = gx % 65536;
      fy = gy % 65536;
      ix1 = (ix + 1 < gw) ? ix + 1 : ix;
      iy1 = (iy + 1 < gh) ? iy + 1 : iy;
      c00 = grid_cells[(iy * gw + ix) % STORE_DEPTH];
      c10 = grid_cells[(iy * gw + ix1) % STORE_DEPTH];
      c01 = grid_cells[(iy1 * gw + ix) % STORE_DEPTH];
      c11 = grid_cells[(iy1 * gw + ix1) % STORE_DEPTH];
      r0 = c00 * 65536 + fx * (c10 - c00);
      r1 = c01 * 65536 + fx * (c11 - c01);
      v = r0 * 65536 + fy * (r1 - r0);
      if (v < 0) v = 0;
      return (v + (longint'(1) << 31)) >>> 32;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] n);
      bit [63:0] r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic bit [63:0] add_sat48(bit [63:0] a, bit [63:0] b);
      bit [63:0] s = a + b;
      return (s > MAX48) ? MAX48 : s;
   endfunction

   function automatic void add_segment(longint ax, longint ay, longint bx, longint by);
      longint dx = bx - ax, dy = by - ay, f;
      bit [63:0] ss, len, s_sum;
      ss = 64'(dx * dx) + 64'(dy * dy);
      len = int_sqrt(ss << 16);
      s_sum = 0;
      for (int q = 0; q < SAMPLES_PER_SEGMENT; q++)
         s_sum += 64'(field_sample(ax, ay, dx, dy, 2 * q + 1));
      obstacle_acc = add_sat48(obstacle_acc, (s_sum * len / SAMPLES_PER_SEGMENT) >> 8);
      for (int q = 0; q <= SAMPLES_PER_SEGMENT; q++) begin
         f = field_sample(ax, ay, dx, dy, 2 * q);
         if (f > peak_acc) peak_acc = f[15:0];
      end
   endfunction

   function automatic void clear_path();
      prev_px = 0; prev_py = 0; older_px = 0; older_py = 0;
      points_held = 0;
      obstacle_acc = 0; smooth_acc = 0; peak_acc = 0;
   endfunction

   // Advances the predictor by one accepted word; returns 1 when a result is due.
   function automatic bit predict_word(op_kind_type op, int idx, int val, int px, int py,
                                       bit last, output path_result_type res);
      longint ax, ay;
      bit [63:0] prod;
      res = '{0, 0};
      if (op == OP_LOAD) begin
         grid_cells[idx] = val[15:0];
         cell_loaded[idx] = 1;
         return 0;
      end
      if (points_held >= 1) add_segment(prev_px, prev_py, px, py);
      if (points_held >= 2) begin
         ax = older_px - 2 * prev_px + px;
         ay = older_py - 2 * prev_py + py;
         smooth_acc = add_sat48(smooth_acc, 64'(ax * ax) + 64'(ay * ay));
      end
      older_px = prev_px; older_py = prev_py;
      prev_px = px; prev_py = py;
      if (points_held < 2) points_held++;
      if (!last) return 0;
      prod = smooth_acc * 64'(weight_reg);
      res.cost = 48'(add_sat48(obstacle_acc, prod >> 8));
      res.peak = peak_acc;
      clear_path();
      return 1;
   endfunction

   task automatic send_word(op_kind_type op, int idx, int val, int px, int py, bit last,
                            bit known = 0, bit [47:0] kcost = 0, bit [15:0] kpeak = 0);
      int gap = req_gaps_on ? $urandom_range(0, 9) : 0;
      path_result_type res;
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = '0;
      req_tdata[11:0] = idx[11:0];
      req_tdata[27:12] = val[15:0];
      req_tdata[43:28] = px[15:0];
      req_tdata[59:44] = py[15:0];
      req_tuser = op;
      req_tlast = last;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      if (predict_word(op, idx, val, px, py, last, res)) begin
         if (known) begin
            res.cost = kcost;
            res.peak = kpeak;
         end
         expected_q.push_back(res);
      end
      @(negedge clock);
   endtask

   task automatic send_load(int idx);
      send_word(OP_LOAD, idx, $urandom_range(0, 65535), $urandom, $urandom, $urandom);
   endtask

   task automatic send_point(int px, int py, bit last);
      send_word(OP_POINT, $urandom_range(0, 4095), $urandom_range(0, 65535), px, py, last);
   endtask

   task automatic wait_idle();
      req_tvalid = 0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, int val);
      csr_index = idx;
      csr_data = val[15:0];
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GRID_WIDTH:    width_reg = val[6:0];
         REG_GRID_HEIGHT:   height_reg = val[6:0];
         REG_CELL_INVERSE:  inverse_reg = val[15:0];
         REG_SMOOTH_WEIGHT: weight_reg = val[15:0];
      endcase
      @(negedge clock);
   endtask

   // Writes all registers, then loads every cell that the new grid shape can read and that is not loaded yet.
   task automatic start_phase(int w, int h, int inv, int wt);
      int cells;
      wait_idle();
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
      write_reg(REG_CELL_INVERSE, inv);
      write_reg(REG_SMOOTH_WEIGHT, wt);
      csr_valid = 0;
      cells = clamp_dim(width_reg, GRID_COLS_MAX) * clamp_dim(height_reg, GRID_ROWS_MAX);
      for (int i = 0; i < cells; i++)
         if (!cell_loaded[i]) send_load(i);
   endtask

   function automatic int pick_coord();
      int span, r = $urandom_range(0, 99);
      span = clamp_dim(width_reg, GRID_COLS_MAX) * 65536 / ((inverse_reg == 0) ? 1 : inverse_reg);
      if (span > 32767) span = 32767;
      if (r < 75) return $urandom_range(0, span) - span / 8;
      if (r < 90) return int'($signed(16'($urandom)));
      case ($urandom_range(0, 2))
         0: return -32768;
         1: return 32767;
         default: return 0;
      endcase
   endfunction

   task automatic random_traffic(int count);
      int sent = 0, path_len;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 12) begin
            send_load($urandom_range(0, 4095));
         end else begin
            path_len = $urandom_range(1, 6);
            for (int p = 0; p < path_len; p++) begin
               if (p > 0 && $urandom_range(0, 9) == 0) send_load($urandom_range(0, 4095));
               send_point(pick_coord(), pick_coord(), p == path_len - 1);
            end
            sent += path_len - 1;
         end
         sent++;
         if ($urandom_range(0, 49) == 0) req_gaps_on = !req_gaps_on;
      end
   endtask

   stim_row_type directed[20] = '{
      '{OP_LOAD,  0,    65535, 0,      0,      0, 0, 0, 0},
      '{OP_LOAD,  5,    0,     0,      0,      0, 0, 0, 0},
      '{OP_LOAD,  4095, 1234,  0,      0,      0, 0, 0, 0},
      '{OP_POINT, 0,    0,     0,      0,      1, 1, 0, 0},
      '{OP_POINT, 0,    0,     0,      0,      0, 0, 0, 0},
      '{OP_POINT, 0,    0,     256,    0,      0, 0, 0, 0},
      '{OP_LOAD,  3,    32768, 0,      0,      0, 0, 0, 0},
      '{OP_POINT, 0,    0,     256,    256,    1, 0, 0, 0},
      '{OP_POINT, 0,    0,     -32768, -32768, 0, 0, 0, 0},
      '{OP_POINT, 0,    0,     32767,  32767,  1, 0, 0, 0},
      '{OP_POINT, 0,    0,     32767,  -32768, 0, 0, 0, 0},
      '{OP_POINT, 0,    0,     -32768, 32767,  0, 0, 0, 0},
      '{OP_POINT, 0,    0,     0,      0,      1, 0, 0, 0},
      '{OP_POINT, 0,    0,     100,    50,     1, 1, 0, 0},
      '{OP_POINT, 0,    0,     0,      0,      0, 0, 0, 0},
      '{OP_POINT, 0,    0,     0,      0,      1, 0, 0, 0},
      '{OP_POINT, 0,    0,     -1,     -1,     0, 0, 0, 0},
      '{OP_POINT, 0,    0,     512,    768,    0, 0, 0, 0},
      '{OP_POINT, 0,    0,     1023,   0,      0, 0, 0, 0},
      '{OP_POINT, 0,    0,     -200,   300,    1, 0, 0, 0}
   };

   // Result side: random gaps, one long hold-off to back the core up.
   initial begin
      int n;
      path_result_type want;
      rsp_tready = 0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         n = rsp_gaps_on ? $urandom_range(0, 9) : 0;
         if (rsp_count == 3) n = PRESSURE_CYCLES;
         if (n > 0) begin
            rsp_tready = 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
         if (expected_q.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            err_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[47:0] !== want.cost) begin
               $error("total_cost expected %0d actual %0d", want.cost, rsp_tdata[47:0]);
               err_count++;
            end
            if (rsp_tdata[63:48] !== want.peak) begin
               $error("peak_value expected %0d actual %0d", want.peak, rsp_tdata[63:48]);
               err_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      int stall_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      reset = 1;
      req_tvalid = 0; req_tdata = '0; req_tuser = 0; req_tlast = 0;
      csr_valid = 0; csr_index = REG_GRID_WIDTH; csr_data = '0;
      width_reg = 64; height_reg = 64; inverse_reg = 256; weight_reg = 256;
      foreach (cell_loaded[i]) cell_loaded[i] = 0;
      clear_path();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      start_phase(4, 4, 256, 256);
      foreach (directed[i]) begin
         row = directed[i];
         send_word(row.op, row.idx, row.val, row.px, row.py, row.last,
                   row.known, row.cost, row.peak);
      end
      random_traffic(60);

      start_phase(8, 8, 256, 256);
      random_traffic(200);
      start_phase(127, 1, 65535, 65535);
      random_traffic(100);
      start_phase(0, 64, 1, 0);
      random_traffic(100);
      start_phase(16, 8, 0, 1000);
      random_traffic(100);
      start_phase(64, 2, 4096, 300);
      random_traffic(150);
      rsp_gaps_on = 0;
      req_gaps_on = 0;
      start_phase(5, 7, 700, 256);
      random_traffic(150);

      wait_idle();
      if (err_count == 0 && expected_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

### path_cost_and_peak_field_core.f
hw/rtl/pcpf_pkg.sv
hw/rtl/pcpf_ram.sv
hw/rtl/pcpf_ctrl.sv
hw/rtl/pcpf_dp.sv
hw/rtl/path_cost_and_peak_field_core.sv
verif/path_cost_and_peak_field_core_tb.sv
